// File: hdl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// Pose frame deframer package
// Shared constants and types for the pose frame deframer blocks.
// ----------------------------------------------------------------------------
package pfd_pkg;

    // Default payload length of one frame in bytes.
    localparam int PAYLOAD_BYTES_DEF = 24;

    // Number of 32-bit words latched from a frame.
    localparam int WORD_COUNT = 6;
    localparam int WORD_W     = 32;

    // Framing bytes.
    localparam logic [7:0] HDR_FIRST  = 8'h0D;
    localparam logic [7:0] HDR_SECOND = 8'h0A;
    localparam logic [7:0] TRL_FIRST  = 8'h0A;
    localparam logic [7:0] TRL_SECOND = 8'h0D;

    // Link timeout register.
    localparam int              TIMEOUT_W     = 16;
    localparam logic [15:0]     TIMEOUT_RESET = 16'd200;
    localparam logic [15:0]     AGE_MAX       = 16'hFFFF;

    // Item kind carried in the mode field.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] t_words;

    // Event from the deframer to the link tracker.
    typedef struct packed {
        logic   done;
        t_words words;
    } t_frame_evt;

endpackage

// File: hdl/pose_frame_deframer.sv
// ----------------------------------------------------------------------------
// Pose frame deframer
// Deframes fixed-length pose frames from a byte stream and tracks link age.
// ----------------------------------------------------------------------------
// Usage: each input beat is either a received serial byte (i_mode low) or a
// one-millisecond tick (i_mode high). Bytes are matched against the header
// 0x0D 0x0A, then PAYLOAD_BYTES payload bytes are collected, then the trailer
// 0x0A 0x0D must follow. A complete frame updates six latched 32-bit words.
// Every input beat produces exactly one output beat carrying the latched words,
// a frame-done pulse and the online flag.
// The input beat is captured in an input register and processed on the way
// into the result register, from which the receiver takes it. One beat is
// accepted every cycle while the receiver keeps taking results; the framing
// and age logic is a short single pass between those two registers.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; the input then stalls until the
// result is taken. The timeout register is written through the config port,
// which is always ready. Reset empties both registers, returns the deframer
// to header hunting, clears the words and the age, and loads a timeout of 200.
// ----------------------------------------------------------------------------
module pose_frame_deframer #(
    parameter int PAYLOAD_BYTES = pfd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [7:0]                     i_rx_byte,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_frame_done,
    output logic                           o_online,
    output logic [pfd_pkg::WORD_W-1:0]     o_word_yaw,
    output logic [pfd_pkg::WORD_W-1:0]     o_word_two,
    output logic [pfd_pkg::WORD_W-1:0]     o_word_three,
    output logic [pfd_pkg::WORD_W-1:0]     o_word_x,
    output logic [pfd_pkg::WORD_W-1:0]     o_word_y,
    output logic [pfd_pkg::WORD_W-1:0]     o_word_rate,
    // Configuration channel (timeout in ticks)
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfd_pkg::TIMEOUT_W-1:0]  i_cfg_data
);

    logic                              r_in_valid;
    logic                              r_mode;
    logic [7:0]                        r_byte;
    logic                              r_out_valid;
    logic                              r_frame_done;
    logic                              r_online;
    logic [pfd_pkg::TIMEOUT_W-1:0]     r_timeout;

    logic                              out_free;
    logic                              advance;
    logic                              in_load;
    logic                              is_tick;
    pfd_pkg::t_frame_evt               evt;
    pfd_pkg::t_words                   words;
    logic                              online_next;

    // The held beat moves into the result register whenever that is free or
    // being emptied this cycle. State changes only on that move, so the
    // latched words seen at the outputs always belong to the held result.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;
    assign is_tick    = (r_mode == pfd_pkg::MODE_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_mode <= i_mode;
            r_byte <= i_rx_byte;
        end
    end

    pfd_deframer #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance && !is_tick),
        .i_byte  (r_byte),
        .o_evt   (evt)
    );

    pfd_link u_link (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_tick        (is_tick),
        .i_evt         (evt),
        .i_timeout     (r_timeout),
        .o_words       (words),
        .o_online_next (online_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_frame_done <= evt.done;
            r_online     <= online_next;
        end
    end

    // Timeout register; the user must write it only while the block is idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= pfd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_done = r_frame_done;
    assign o_online     = r_online;
    assign o_word_yaw   = words[0];
    assign o_word_two   = words[1];
    assign o_word_three = words[2];
    assign o_word_x     = words[3];
    assign o_word_y     = words[4];
    assign o_word_rate  = words[5];

endmodule

// File: hdl/pfd_deframer.sv
// ----------------------------------------------------------------------------
// Pose frame deframer: byte framing
// Tracks header, payload and trailer phases and collects payload bytes.
// ----------------------------------------------------------------------------
module pfd_deframer #(
    parameter int PAYLOAD_BYTES = pfd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output pfd_pkg::t_frame_evt o_evt
);

    localparam int IDX_W = $clog2(PAYLOAD_BYTES);

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_TRL1 = 3'd3;
    localparam logic [2:0] PH_TRL2 = 3'd4;

    logic [2:0]                        r_phase, n_phase;
    logic [IDX_W-1:0]                  r_idx, n_idx;
    logic [PAYLOAD_BYTES-1:0][7:0]     r_buf;
    logic [IDX_W:0]                    idx_inc;
    logic                              buf_we;
    logic                              done;

    assign idx_inc = {1'b0, r_idx} + {{IDX_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        buf_we  = 1'b0;
        done    = 1'b0;
        case (r_phase)
            PH_HDR1: begin
                n_phase = (i_byte == pfd_pkg::HDR_FIRST) ? PH_HDR2 : PH_HDR1;
            end
            PH_HDR2: begin
                if (i_byte == pfd_pkg::HDR_SECOND) begin
                    n_idx   = '0;
                    n_phase = PH_DATA;
                end else if (i_byte == pfd_pkg::HDR_FIRST) begin
                    n_phase = PH_HDR2;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_DATA: begin
                buf_we = 1'b1;
                if (idx_inc >= (IDX_W+1)'(PAYLOAD_BYTES)) begin
                    n_idx   = '0;
                    n_phase = PH_TRL1;
                end else begin
                    n_idx = idx_inc[IDX_W-1:0];
                end
            end
            PH_TRL1: begin
                n_phase = (i_byte == pfd_pkg::TRL_FIRST) ? PH_TRL2 : PH_HDR1;
            end
            PH_TRL2: begin
                done    = (i_byte == pfd_pkg::TRL_SECOND);
                n_phase = PH_HDR1;
            end
            default: begin
                n_phase = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
            r_idx   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && buf_we) begin
            r_buf[r_idx] <= i_byte;
        end
    end

    // Little-endian word assembly; bytes past the payload read as zero.
    for (genvar k = 0; k < pfd_pkg::WORD_COUNT; k++) begin : g_word
        for (genvar j = 0; j < 4; j++) begin : g_byte
            if (4*k + j < PAYLOAD_BYTES) begin : g_used
                assign o_evt.words[k][8*j +: 8] = r_buf[4*k + j];
            end else begin : g_zero
                assign o_evt.words[k][8*j +: 8] = 8'h00;
            end
        end
    end

    assign o_evt.done = i_step && done;

endmodule

// File: hdl/pfd_link.sv
// ----------------------------------------------------------------------------
// Pose frame deframer: link tracker
// Holds the latched words, the has-frame mark and the saturating tick age.
// ----------------------------------------------------------------------------
module pfd_link (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  logic                               i_tick,
    input  pfd_pkg::t_frame_evt                i_evt,
    input  logic [pfd_pkg::TIMEOUT_W-1:0]      i_timeout,
    output pfd_pkg::t_words                    o_words,
    output logic                               o_online_next
);

    pfd_pkg::t_words                   r_words;
    logic                              r_has_frame, n_has_frame;
    logic [pfd_pkg::TIMEOUT_W-1:0]     r_age, n_age;

    always_comb begin
        n_has_frame = r_has_frame;
        n_age       = r_age;
        if (i_tick) begin
            if (r_age != pfd_pkg::AGE_MAX) begin
                n_age = r_age + 16'd1;
            end
        end else if (i_evt.done) begin
            n_has_frame = 1'b1;
            n_age       = '0;
        end
    end

    // Online as seen after the current item is applied.
    assign o_online_next = n_has_frame && (n_age < i_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words     <= '0;
            r_has_frame <= 1'b0;
            r_age       <= '0;
        end else if (i_step) begin
            r_has_frame <= n_has_frame;
            r_age       <= n_age;
            if (!i_tick && i_evt.done) begin
                r_words <= i_evt.words;
            end
        end
    end

    assign o_words = r_words;

endmodule

// File: hdl/pfd_checker.sv
// ----------------------------------------------------------------------------
// Pose frame deframer checker
// Port-level assertions on the deframer's handshakes and latched words.
// ----------------------------------------------------------------------------
module pfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_frame_done,
    input logic                        o_online,
    input logic [pfd_pkg::WORD_W-1:0]  o_word_yaw,
    input logic [pfd_pkg::WORD_W-1:0]  o_word_rate
);

    // The input only stalls while a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_frame_done) && $stable(o_online)
             && $stable(o_word_yaw) && $stable(o_word_rate)))
        else $error("stalled result beat changed");

    // Latched words only change together with a frame-done beat.
    a_words_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (!$stable(o_word_yaw) || !$stable(o_word_rate)))
            |-> (o_out_valid && o_frame_done))
        else $error("latched words changed without a completed frame");

    // A result that shows up on an empty output comes from an input beat that
    // was accepted and passed through the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid))
            |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result beat without an accepted input beat");

endmodule

bind pose_frame_deframer pfd_checker u_pfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_frame_done (o_frame_done),
    .o_online     (o_online),
    .o_word_yaw   (o_word_yaw),
    .o_word_rate  (o_word_rate)
);

// File: verif/pose_frame_deframer_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pose frame deframer checker
// Watches the input, output and timeout channels of the deframer, keeps its
// own copy of the framing and link-age state, and compares every result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module pose_frame_deframer_chk #(
    parameter int PAYLOAD_BYTES = pfd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_mode,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_frame_done,
    input  logic                          i_online,
    input  logic [pfd_pkg::WORD_W-1:0]    i_word_yaw,
    input  logic [pfd_pkg::WORD_W-1:0]    i_word_two,
    input  logic [pfd_pkg::WORD_W-1:0]    i_word_three,
    input  logic [pfd_pkg::WORD_W-1:0]    i_word_x,
    input  logic [pfd_pkg::WORD_W-1:0]    i_word_y,
    input  logic [pfd_pkg::WORD_W-1:0]    i_word_rate,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pfd_pkg::TIMEOUT_W-1:0] i_cfg_data,
    input  logic                          i_final_check,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_frames
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_TRL1 = 3'd3;
    localparam logic [2:0] PH_TRL2 = 3'd4;

    typedef struct packed {
        logic            done;
        logic            online;
        pfd_pkg::t_words words;
    } t_pose_result;

    logic [2:0]                    link_phase;
    logic [4:0]                    body_idx;
    logic [7:0]                    body_buf [32];
    pfd_pkg::t_words               held_words;
    logic                          has_frame;
    logic [pfd_pkg::TIMEOUT_W-1:0] age_ticks;
    logic [pfd_pkg::TIMEOUT_W-1:0] timeout_ticks;
    t_pose_result                  pose_q [$];
    int                            results_seen;
    string                         word_names [pfd_pkg::WORD_COUNT] =
        '{"word_yaw", "word_two", "word_three", "word_x", "word_y", "word_rate"};

    // Advances the deframer and link age by one beat and returns the result
    // that beat should produce.
    function automatic t_pose_result step_pose(input logic mode, input logic [7:0] b);
        t_pose_result res;
        int           pos;
        res.done = 1'b0;
        if (mode == pfd_pkg::MODE_TICK) begin
            if (age_ticks != pfd_pkg::AGE_MAX)
                age_ticks = age_ticks + 16'd1;
        end else begin
            case (link_phase)
                PH_HUNT: begin
                    link_phase = (b == pfd_pkg::HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                end
                PH_HDR2: begin
                    if (b == pfd_pkg::HDR_SECOND) begin
                        body_idx   = '0;
                        link_phase = PH_BODY;
                    end else if (b != pfd_pkg::HDR_FIRST) begin
                        link_phase = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    body_buf[body_idx] = b;
                    body_idx = body_idx + 5'd1;
                    if (body_idx == 5'd0 || int'(body_idx) >= PAYLOAD_BYTES) begin
                        body_idx   = '0;
                        link_phase = PH_TRL1;
                    end
                end
                PH_TRL1: begin
                    link_phase = (b == pfd_pkg::TRL_FIRST) ? PH_TRL2 : PH_HUNT;
                end
                PH_TRL2: begin
                    if (b == pfd_pkg::TRL_SECOND) begin
                        // Payload byte 4k is the low byte of word k.
                        for (int k = 0; k < pfd_pkg::WORD_COUNT; k++) begin
                            for (int j = 0; j < 4; j++) begin
                                pos = 4 * k + j;
                                held_words[k][8*j +: 8] =
                                    (pos < PAYLOAD_BYTES) ? body_buf[pos] : 8'h00;
                            end
                        end
                        has_frame = 1'b1;
                        age_ticks = '0;
                        res.done  = 1'b1;
                    end
                    link_phase = PH_HUNT;
                end
                default: begin
                    link_phase = PH_HUNT;
                end
            endcase
        end
        res.online = has_frame && (age_ticks < timeout_ticks);
        res.words  = held_words;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 40)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_pose_result    want;
        pfd_pkg::t_words got_words;
        if (!i_rst_n) begin
            link_phase    = PH_HUNT;
            body_idx      = '0;
            held_words    = '0;
            has_frame     = 1'b0;
            age_ticks     = '0;
            timeout_ticks = pfd_pkg::TIMEOUT_RESET;
            results_seen  = 0;
            o_fail_count  = 0;
            o_frames      = 0;
            pose_q.delete();
        end else begin
            // Results first: a result never belongs to a beat taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                got_words = {i_word_rate, i_word_y, i_word_x,
                             i_word_three, i_word_two, i_word_yaw};
                if (pose_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, 0);
                end else begin
                    want = pose_q.pop_front();
                    if (i_frame_done !== want.done)
                        report_mismatch("frame_done", 32'(i_frame_done), 32'(want.done));
                    if (i_online !== want.online)
                        report_mismatch("online", 32'(i_online), 32'(want.online));
                    for (int k = 0; k < pfd_pkg::WORD_COUNT; k++)
                        if (got_words[k] !== want.words[k])
                            report_mismatch(word_names[k], got_words[k], want.words[k]);
                end
                results_seen++;
            end
            if (i_cfg_valid && i_cfg_ready)
                timeout_ticks = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                want = step_pose(i_mode, i_rx_byte);
                if (want.done)
                    o_frames++;
                pose_q.push_back(want);
            end
            if (i_final_check) begin
                while (pose_q.size() != 0) begin
                    void'(pose_q.pop_front());
                    report_mismatch("result never delivered", 0, 0);
                end
            end
        end
        o_pending = pose_q.size();
    end

endmodule

// File: verif/pose_frame_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pose frame deframer testbench
// Drives serial bytes and millisecond ticks into the deframer under four
// idling mixes and a range of link timeouts.
// A checker beside the block predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------
module pose_frame_deframer_tb;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic                          in_mode   = pfd_pkg::MODE_BYTE;
    logic [7:0]                    in_byte   = 8'h00;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          frame_done;
    logic                          online;
    logic [pfd_pkg::WORD_W-1:0]    word_yaw, word_two, word_three, word_x, word_y, word_rate;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [pfd_pkg::TIMEOUT_W-1:0] cfg_data  = '0;
    logic                          final_check = 1'b0;
    int                            fail_count, pending, frames;

    // Idling controls, in percent of cycles.
    int                            idle_pct  = 0;
    int                            stall_pct = 0;
    int                            beats_sent = 0;
    int                            timeout_writes = 0;
    logic [pfd_pkg::TIMEOUT_W-1:0] cur_timeout = pfd_pkg::TIMEOUT_RESET;

    // Timeout settings: the extremes, a zero register and a few short ones so
    // that tick bursts can actually take the link offline.
    logic [pfd_pkg::TIMEOUT_W-1:0] timeout_tab [8] = '{16'd1, 16'hFFFF, 16'd12, 16'd0,
                                                       16'd3, 16'd500, 16'd2, 16'd200};
    int                            send_idle_tab [4] = '{0, 70, 0, 36};
    int                            recv_stall_tab [4] = '{0, 0, 70, 36};

    pose_frame_deframer u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_mode       (in_mode),
        .i_rx_byte    (in_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_frame_done (frame_done),
        .o_online     (online),
        .o_word_yaw   (word_yaw),
        .o_word_two   (word_two),
        .o_word_three (word_three),
        .o_word_x     (word_x),
        .o_word_y     (word_y),
        .o_word_rate  (word_rate),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    pose_frame_deframer_chk u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_mode        (in_mode),
        .i_rx_byte     (in_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_frame_done  (frame_done),
        .i_online      (online),
        .i_word_yaw    (word_yaw),
        .i_word_two    (word_two),
        .i_word_three  (word_three),
        .i_word_x      (word_x),
        .i_word_y      (word_y),
        .i_word_rate   (word_rate),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_final_check (final_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_frames      (frames)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The receiver stalls on a random share of cycles set by the current mix.
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Every task below is entered and left just after a rising edge. Handshake
    // inputs are looked at on the falling edge, where everything driven at the
    // rising edge has settled, so the decision holds for the next rising edge.
    task automatic send_beat(input logic mode, input logic [7:0] data);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_byte  <= data;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        beats_sent++;
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Only called once the block is drained.
    task automatic write_timeout(input logic [pfd_pkg::TIMEOUT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        cur_timeout = value;
        timeout_writes++;
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v == a || v == b);
        return v;
    endfunction

    // Payload bytes lean toward the framing bytes and the extremes so that
    // header and trailer look-alikes show up inside frames.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(9))
            0: return pfd_pkg::HDR_FIRST;
            1: return pfd_pkg::HDR_SECOND;
            2: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_tick();
        send_beat(pfd_pkg::MODE_TICK, 8'($urandom_range(255)));
    endtask

    // Sends count payload bytes; ticks may fall between them, which must not
    // disturb the deframer.
    task automatic send_payload(input int count, input bit with_ticks);
        for (int i = 0; i < count; i++) begin
            if (with_ticks && $urandom_range(9) == 0)
                send_random_tick();
            send_beat(pfd_pkg::MODE_BYTE, payload_byte());
        end
    endtask

    task automatic send_frame(input bit with_ticks);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_SECOND);
        send_payload(pfd_pkg::PAYLOAD_BYTES_DEF, with_ticks);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::TRL_FIRST);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::TRL_SECOND);
    endtask

    task automatic run_directed();
        // Hunting state sees the byte extremes and both tick encodings.
        send_beat(pfd_pkg::MODE_BYTE, 8'h00);
        send_beat(pfd_pkg::MODE_BYTE, 8'hFF);
        send_beat(pfd_pkg::MODE_TICK, 8'hFF);
        send_beat(pfd_pkg::MODE_TICK, 8'h00);
        // A wrong second header byte sends the search back to the start.
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
        send_beat(pfd_pkg::MODE_BYTE, 8'h55);
        // A repeated header start keeps waiting for the second header byte.
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
        send_frame(1'b0);
        // Wrong first trailer byte: no frame.
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_SECOND);
        send_payload(pfd_pkg::PAYLOAD_BYTES_DEF, 1'b0);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::TRL_SECOND);
        // Wrong final trailer byte: the frame is dropped.
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_SECOND);
        send_payload(pfd_pkg::PAYLOAD_BYTES_DEF, 1'b1);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::TRL_FIRST);
        send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::TRL_FIRST);
        send_random_tick();
    endtask

    task automatic run_sequence();
        int pick;
        int burst;
        pick = $urandom_range(99);
        if ($urandom_range(49) == 0)
            wait_drained();
        if (pick < 60) begin
            // Well-formed frame, sometimes after extra header starts or a stray byte.
            if ($urandom_range(3) == 0)
                send_beat(pfd_pkg::MODE_BYTE, payload_byte());
            repeat ($urandom_range(2)) send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
            send_frame(1'($urandom_range(1)));
        end else if (pick < 75) begin
            // Tick bursts; with short timeouts they often run past the limit.
            if ($urandom_range(2) == 0 && cur_timeout <= 600)
                burst = $urandom_range(int'(cur_timeout) + 3, 1);
            else
                burst = $urandom_range(6, 1);
            repeat (burst) send_random_tick();
        end else if (pick < 92) begin
            // Broken frames, each failing at a different point.
            send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_FIRST);
            case ($urandom_range(3))
                0: send_beat(pfd_pkg::MODE_BYTE,
                             byte_other_than(pfd_pkg::HDR_FIRST, pfd_pkg::HDR_SECOND));
                1: begin
                    send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_SECOND);
                    send_payload(pfd_pkg::PAYLOAD_BYTES_DEF, 1'b1);
                    send_beat(pfd_pkg::MODE_BYTE,
                              byte_other_than(pfd_pkg::TRL_FIRST, pfd_pkg::TRL_FIRST));
                end
                2: begin
                    send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_SECOND);
                    send_payload(pfd_pkg::PAYLOAD_BYTES_DEF, 1'b1);
                    send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::TRL_FIRST);
                    send_beat(pfd_pkg::MODE_BYTE,
                              byte_other_than(pfd_pkg::TRL_SECOND, pfd_pkg::TRL_SECOND));
                end
                default: begin
                    // Cut short: the next sequence lands inside the payload.
                    send_beat(pfd_pkg::MODE_BYTE, pfd_pkg::HDR_SECOND);
                    send_payload($urandom_range(pfd_pkg::PAYLOAD_BYTES_DEF - 1, 1), 1'b0);
                end
            endcase
        end else begin
            repeat ($urandom_range(6, 1))
                send_beat(pfd_pkg::MODE_BYTE, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs with the reset timeout and no idling.
        run_directed();

        // Four idling mixes, two timeout settings each.
        for (int m = 0; m < 4; m++) begin
            idle_pct  = send_idle_tab[m];
            stall_pct = recv_stall_tab[m];
            for (int h = 0; h < 2; h++) begin
                wait_drained();
                write_timeout(timeout_tab[2*m + h]);
                target = beats_sent + 200;
                while (beats_sent < target)
                    run_sequence();
            end
        end

        // Drain, let the pipeline settle, then flag anything still owed.
        wait_drained();
        repeat (8) @(posedge clk);
        final_check <= 1'b1;
        @(posedge clk);
        final_check <= 1'b0;
        @(negedge clk);

        $display("summary: %0d beats in, %0d complete frames, %0d timeout writes",
                 beats_sent, frames, timeout_writes);
        $display("summary: directed framing cases and four idling mixes, %0d mismatches",
                 fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(64'd20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
